### hdl/ctb_pkg.sv
// ctb_pkg: types and constants shared by the timer bank modules.
// No dependencies; imported by ctb_ctrl, ctb_datapath and cookie_timer_bank.
`default_nettype none

package ctb_pkg;

    localparam logic [15:0] COOKIE_INVALID = 16'hFFFF;
    localparam int          MAX_TIMEOUTS   = 8;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic {
        KIND_STATUS  = 1'b0,
        KIND_TIMEOUT = 1'b1
    } t_kind;

    typedef struct packed {
        t_op         op;
        logic [2:0]  timer_index;
        logic [15:0] timeout_ticks;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  which_timer;
        logic [15:0] cookie;
        logic [15:0] remaining;
        logic        done_res;
        logic        last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture the accepted item, clear scan state
        logic single_fire; // finish start/stop/query: write and push result
        logic tick_step;   // finish one timer of the tick scan
        logic flush;       // push the held timeout as the final result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;    // output register can take an item this cycle
        logic new_to;      // timer under scan times out now
        logic pend_valid;  // a timeout is held back for the last flag
        logic scan_last;   // timer under scan is the highest index
    } t_dp_sts;

endpackage

`default_nettype wire

### hdl/ctb_datapath.sv
// ctb_datapath: count/cookie memories, cookie generator, held timeout and
// output register. Depends on ctb_pkg; driven by ctb_ctrl.
`default_nettype none

module ctb_datapath import ctb_pkg::*; #(
    parameter int TIMER_COUNT = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_in_item,
    input  wire t_dp_cmd   i_cmd,
    output t_dp_sts        o_sts,
    input  wire logic      i_out_stall,
    output logic           o_out_valid,
    output t_out_item      o_out_item
);

    localparam int AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam logic [6:0] TC7 = 7'(TIMER_COUNT);

    logic [15:0]      counts_mem  [TIMER_COUNT];
    logic [15:0]      cookies_mem [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] r_valid;

    t_in_item         r_item;
    logic [AW-1:0]    r_scan;
    logic [3:0]       r_n;
    logic [15:0]      r_next_cookie;
    logic [15:0]      r_rd_count;
    logic [15:0]      r_rd_cookie;
    logic             r_rd_valid;
    t_out_item        r_pend;
    logic             r_pend_valid;
    t_out_item        r_out;
    logic             r_out_valid;

    logic [6:0]       idx_ext;
    logic [6:0]       scan_ext;
    logic [AW-1:0]    addr;
    logic             in_range;
    logic [15:0]      rd_count;
    logic [15:0]      rd_cookie;
    logic [15:0]      cookie_new;
    logic             out_free;
    logic             new_to;
    logic             push;
    t_out_item        single_res;
    t_out_item        to_res;
    t_out_item        push_item;
    logic             we;
    logic             we_cookie;
    logic [15:0]      wr_count;
    logic [15:0]      wr_cookie;

    assign idx_ext  = {4'b0, r_item.timer_index};
    assign scan_ext = 7'(r_scan);
    assign addr     = (r_item.op == OP_TICK) ? r_scan : AW'(idx_ext);
    assign in_range = idx_ext < TC7;
    assign rd_count  = r_rd_valid ? r_rd_count  : 16'd0;
    assign rd_cookie = r_rd_valid ? r_rd_cookie : 16'd0;
    assign cookie_new = (r_next_cookie + 16'd1 == COOKIE_INVALID) ? 16'd0
                                                                  : r_next_cookie + 16'd1;
    assign out_free = !r_out_valid || !i_out_stall;
    assign new_to   = (rd_count == 16'd1) && !r_n[3];

    assign o_sts.out_free   = out_free;
    assign o_sts.new_to     = new_to;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.scan_last  = (scan_ext == TC7 - 7'd1);

    always_comb begin
        single_res.kind        = KIND_STATUS;
        single_res.which_timer = r_item.timer_index;
        single_res.cookie      = COOKIE_INVALID;
        single_res.remaining   = 16'd0;
        single_res.last        = 1'b1;
        if (in_range) begin
            case (r_item.op)
                OP_START: begin
                    single_res.kind      = (r_item.timeout_ticks == 16'd0) ? KIND_TIMEOUT
                                                                           : KIND_STATUS;
                    single_res.cookie    = cookie_new;
                    single_res.remaining = r_item.timeout_ticks;
                end
                OP_QUERY: begin
                    single_res.cookie    = rd_cookie;
                    single_res.remaining = rd_count;
                end
                default: begin
                end
            endcase
        end
        single_res.done_res = (single_res.remaining == 16'd0);

        to_res.kind        = KIND_TIMEOUT;
        to_res.which_timer = scan_ext[2:0];
        to_res.cookie      = rd_cookie;
        to_res.remaining   = 16'd0;
        to_res.done_res    = 1'b1;
        to_res.last        = 1'b0;
    end

    // result into the output register
    always_comb begin
        push      = 1'b0;
        push_item = single_res;
        if (i_cmd.single_fire) begin
            push = 1'b1;
        end else if (i_cmd.tick_step && new_to && r_pend_valid) begin
            push      = 1'b1;
            push_item = r_pend;
        end else if (i_cmd.flush) begin
            push      = 1'b1;
            push_item = r_pend;
            push_item.last = 1'b1;
        end
    end

    // memory write side
    always_comb begin
        we        = 1'b0;
        we_cookie = 1'b0;
        wr_count  = rd_count - 16'd1;
        wr_cookie = COOKIE_INVALID;
        if (i_cmd.single_fire && in_range) begin
            case (r_item.op)
                OP_START: begin
                    we        = 1'b1;
                    we_cookie = 1'b1;
                    wr_count  = r_item.timeout_ticks;
                    wr_cookie = cookie_new;
                end
                OP_STOP: begin
                    we        = 1'b1;
                    we_cookie = 1'b1;
                    wr_count  = 16'd0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.tick_step && rd_count != 16'd0) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            counts_mem[addr] <= wr_count;
        end
        if (we_cookie) begin
            cookies_mem[addr] <= wr_cookie;
        end
        r_rd_count  <= counts_mem[addr];
        r_rd_cookie <= cookies_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_rd_valid    <= 1'b0;
            r_next_cookie <= 16'd0;
            r_pend_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
            r_scan        <= '0;
            r_n           <= 4'd0;
        end else begin
            r_rd_valid <= r_valid[addr];
            if (we) begin
                r_valid[addr] <= 1'b1;
            end
            if (i_cmd.single_fire && in_range && r_item.op == OP_START) begin
                r_next_cookie <= cookie_new;
            end
            if (i_cmd.load) begin
                r_scan       <= '0;
                r_n          <= 4'd0;
                r_pend_valid <= 1'b0;
            end else if (i_cmd.tick_step) begin
                r_scan <= r_scan + AW'(1);
                if (new_to) begin
                    r_n          <= r_n + 4'd1;
                    r_pend_valid <= 1'b1;
                end
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.tick_step && new_to) begin
            r_pend <= to_res;
        end
        if (push) begin
            r_out <= push_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

### hdl/ctb_ctrl.sv
// ctb_ctrl: sequencer for single operations and the tick scan.
// Depends on ctb_pkg; commands ctb_datapath through t_dp_cmd / t_dp_sts.
`default_nettype none

module ctb_ctrl import ctb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_op     i_op,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_in_stall
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_EXEC = 5'b00100,
        S_TRD  = 5'b01000,
        S_TCHK = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   tick_adv;

    // a second timeout may only replace the held one if the held one can leave
    assign tick_adv = !(i_sts.new_to && i_sts.pend_valid && !i_sts.out_free);

    always_comb begin
        n_state           = r_state;
        o_cmd.load        = 1'b0;
        o_cmd.single_fire = 1'b0;
        o_cmd.tick_step   = 1'b0;
        o_cmd.flush       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_op == OP_TICK) ? S_TRD : S_RD;
                end
            end
            S_RD: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.single_fire = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_TRD: begin
                if (i_sts.scan_last || !i_sts.pend_valid) begin
                    n_state = S_TCHK;
                end else begin
                    n_state = S_TCHK;
                end
            end
            S_TCHK: begin
                if (tick_adv) begin
                    o_cmd.tick_step = 1'b1;
                    if (!i_sts.scan_last) begin
                        n_state = S_TRD;
                    end else if (i_sts.new_to || i_sts.pend_valid) begin
                        // held timeout goes out as the final result
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // final flush happens in idle before the next item is taken
        if (r_state == S_IDLE && i_sts.pend_valid) begin
            o_cmd.load = 1'b0;
            n_state    = S_IDLE;
            if (i_sts.out_free) begin
                o_cmd.flush = 1'b1;
            end
        end
    end

    assign o_in_stall = (r_state != S_IDLE) || i_sts.pend_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### hdl/cookie_timer_bank.sv
// cookie_timer_bank: top level of the countdown timer bank.
// Depends on ctb_pkg, ctb_ctrl and ctb_datapath.
//
//   channel   direction  handshake                       payload
//   in        input      i_in_valid  / o_in_stall        i_in_item  (t_in_item)
//   out       output     o_out_valid / i_out_stall       o_out_item (t_out_item)
//
// Start, stop and query go through accept, memory read and execute/write in turn.
// A tick reads then updates each timer in turn through the single port of the
// count/cookie memories, then releases the final timeout with its last flag
// when the tick produced any.
// Reset clears per-timer valid bits at once; an entry never written reads as
// zero count and zero cookie. No clearing pass is needed.
// A stalled output holds the scan on the timer that would need to push.
`default_nettype none

module cookie_timer_bank import ctb_pkg::*; #(
    parameter int TIMER_COUNT = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: decides when each timer step or result may go
    ctb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_item.op),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // storage, cookie generator and output register
    ctb_datapath #(
        .TIMER_COUNT (TIMER_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
